// ----- rtl/tpc_pkg.sv -----
// Shared types and constants of the trie prefix counter.
// Used by tpc_walk and trie_prefix_counter_core; depends on nothing else.
`default_nettype none

package tpc_pkg;

  localparam int LETTER_BITS = 5;
  localparam int PREFIX_BITS = 16;

  localparam logic [PREFIX_BITS-1:0] PREFIX_MAX = 16'hFFFF;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One letter of a word as it travels from the input port to the walker.
  typedef struct packed {
    logic                   cmd;
    logic [LETTER_BITS-1:0] letter;
    logic                   word_end;
  } item_t;

  // One result item as it leaves the walker.
  typedef struct packed {
    logic [PREFIX_BITS-1:0] prefix_count;
    logic                   status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/tpc_ram.sv -----
// Simple dual-port synchronous memory, one write and one registered read per cycle.
// Holds either the child table or the visit counts; no package dependency.
`default_nettype none

module tpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rd_data,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tpc_walk.sv -----
// Letter sequencer: reads a child pointer, allocates or follows it, and updates or
// reads the visit count of the node reached. Uses tpc_pkg; drives two tpc_ram instances.
`default_nettype none

module tpc_walk #(
  parameter int NODE_COUNT = 1024,
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 16,
  localparam int NODE_BITS  = $clog2(NODE_COUNT),
  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET,
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tpc_pkg::item_t        in_item,
  output logic                       res_valid,
  output tpc_pkg::res_t              res,
  input  wire logic                  res_ready,
  output logic                       child_rd_en,
  output logic [SLOT_BITS-1:0]       child_raddr,
  input  wire logic [NODE_BITS-1:0]  child_q,
  output logic                       child_we,
  output logic [SLOT_BITS-1:0]       child_waddr,
  output logic [NODE_BITS-1:0]       child_wdata,
  output logic                       cnt_rd_en,
  output logic [NODE_BITS-1:0]       cnt_raddr,
  input  wire logic [COUNT_BITS-1:0] cnt_q,
  output logic                       cnt_we,
  output logic [NODE_BITS-1:0]       cnt_waddr,
  output logic [COUNT_BITS-1:0]      cnt_wdata
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_CNT   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  localparam logic [SLOT_BITS-1:0]  SLOT_LAST = SLOT_BITS'(SLOT_COUNT - 1);
  localparam logic [NODE_BITS:0]    FREE_END  = (NODE_BITS + 1)'(NODE_COUNT);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [2:0]            state_r, state_nxt;
  logic [SLOT_BITS-1:0]  clr_r, clr_nxt;
  tpc_pkg::item_t        item_r, item_nxt;
  logic [SLOT_BITS-1:0]  slot_r, slot_nxt;
  logic [NODE_BITS-1:0]  cur_r, cur_nxt;
  logic [NODE_BITS:0]    free_r, free_nxt;
  logic                  broken_r, broken_nxt;
  logic                  full_r, full_nxt;
  tpc_pkg::res_t         pend_r, pend_nxt;

  logic [SLOT_BITS-1:0]  slot_calc;
  logic                  letter_ok;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           cnt_ext;
  logic [15:0]           cnt_sat;
  logic                  fin;
  tpc_pkg::res_t         fin_res;

  assign slot_calc = SLOT_BITS'(cur_r) * SLOT_BITS'(ALPHABET) + SLOT_BITS'(in_item.letter);
  assign letter_ok = 32'(item_r.letter) < ALPHABET;
  assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign cnt_ext   = 32'(cnt_q);
  assign cnt_sat   = (cnt_ext > 32'(tpc_pkg::PREFIX_MAX)) ? tpc_pkg::PREFIX_MAX : cnt_ext[15:0];
  assign in_stall  = (state_r != ST_IDLE);

  // The root is never the node reached by a query that ends unbroken, so its
  // visit count is never read back and is not kept.
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    item_nxt    = item_r;
    slot_nxt    = slot_r;
    cur_nxt     = cur_r;
    free_nxt    = free_r;
    broken_nxt  = broken_r;
    full_nxt    = full_r;
    pend_nxt    = pend_r;
    child_rd_en = 1'b0;
    child_raddr = slot_calc;
    child_we    = 1'b0;
    child_waddr = clr_r;
    child_wdata = '0;
    cnt_rd_en   = 1'b0;
    cnt_raddr   = child_q;
    cnt_we      = 1'b0;
    cnt_waddr   = cur_r;
    cnt_wdata   = cnt_inc;
    fin         = 1'b0;
    fin_res.prefix_count = '0;
    fin_res.status       = tpc_pkg::STATUS_OK;
    res_valid   = 1'b0;
    res         = pend_r;

    unique case (state_r)
      ST_CLEAR: begin
        child_we = 1'b1;
        if (clr_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + SLOT_BITS'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_item;
          slot_nxt    = slot_calc;
          child_rd_en = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (item_r.cmd == tpc_pkg::CMD_INSERT) begin
          if (full_r || broken_r || !letter_ok) begin
            fin = 1'b1;
          end else if (child_q == '0) begin
            if (free_r == FREE_END) begin
              full_nxt = 1'b1;
              fin      = 1'b1;
            end else begin
              // A fresh node starts with a count of one: this word.
              child_we    = 1'b1;
              child_waddr = slot_r;
              child_wdata = free_r[NODE_BITS-1:0];
              cnt_we      = 1'b1;
              cnt_waddr   = free_r[NODE_BITS-1:0];
              cnt_wdata   = COUNT_BITS'(1);
              cur_nxt     = free_r[NODE_BITS-1:0];
              free_nxt    = free_r + (NODE_BITS + 1)'(1);
              fin         = 1'b1;
            end
          end else begin
            cur_nxt   = child_q;
            cnt_rd_en = 1'b1;
            state_nxt = ST_CNT;
          end
        end else begin
          if (broken_r) begin
            fin = 1'b1;
          end else if (!letter_ok || child_q == '0) begin
            broken_nxt = 1'b1;
            fin        = 1'b1;
          end else begin
            cur_nxt = child_q;
            if (item_r.word_end) begin
              cnt_rd_en = 1'b1;
              state_nxt = ST_CNT;
            end else begin
              fin = 1'b1;
            end
          end
        end
      end
      ST_CNT: begin
        fin = 1'b1;
        if (item_r.cmd == tpc_pkg::CMD_INSERT) begin
          cnt_we = 1'b1;
        end else begin
          fin_res.prefix_count = cnt_sat;
        end
      end
      ST_WAIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (fin) begin
      if (item_r.word_end) begin
        if (item_r.cmd == tpc_pkg::CMD_INSERT) begin
          fin_res.status = full_nxt;
        end
        cur_nxt    = '0;
        broken_nxt = 1'b0;
        full_nxt   = 1'b0;
        res_valid  = 1'b1;
        res        = fin_res;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end else begin
          pend_nxt  = fin_res;
          state_nxt = ST_WAIT;
        end
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      cur_r    <= '0;
      free_r   <= (NODE_BITS + 1)'(1);
      broken_r <= 1'b0;
      full_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cur_r    <= cur_nxt;
      free_r   <= free_nxt;
      broken_r <= broken_nxt;
      full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    slot_r <= slot_nxt;
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/trie_prefix_counter_core.sv -----
// Top level of the trie prefix counter: letter walker, child table, visit counts
// and output register. Uses tpc_pkg, tpc_walk and tpc_ram.
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_cmd, in_letter,  | letters in
//          | in_word_end                             |
//  result  | out_valid, out_stall, out_prefix_count, | one item per
//          | out_status                              | word end
//
// A letter passes the idle and look-up states when it allocates a node, is
// ignored, or is a query letter that is not the last; it also passes the count
// state when an insert follows an existing child or a query ends on a node: the
// child-table read, then the visit-count read (and write, for an insert).
// After reset all NODE_COUNT*ALPHABET child-table slots (26624 by default) are
// cleared, with in_stall high. A result waits in the output register; if that
// register is still stalled when the next word ends, the walker holds it too.
`default_nettype none

module trie_prefix_counter_core #(
  parameter int NODE_COUNT = 1024,
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [4:0]  in_letter,
  input  wire logic        in_word_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_prefix_count,
  output logic             out_status
);

  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

  tpc_pkg::item_t        in_item;
  tpc_pkg::res_t         res;
  logic                  res_valid;
  logic                  res_ready;

  logic                  child_rd_en;
  logic [SLOT_BITS-1:0]  child_raddr;
  logic [NODE_BITS-1:0]  child_q;
  logic                  child_we;
  logic [SLOT_BITS-1:0]  child_waddr;
  logic [NODE_BITS-1:0]  child_wdata;
  logic                  cnt_rd_en;
  logic [NODE_BITS-1:0]  cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  cnt_we;
  logic [NODE_BITS-1:0]  cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic                  out_valid_r;
  logic [15:0]           out_prefix_count_r;
  logic                  out_status_r;

  assign in_item.cmd      = in_cmd;
  assign in_item.letter   = in_letter;
  assign in_item.word_end = in_word_end;

  assign res_ready = !out_valid_r || !out_stall;

  tpc_walk #(
    .NODE_COUNT (NODE_COUNT),
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready),
    .child_rd_en (child_rd_en),
    .child_raddr (child_raddr),
    .child_q     (child_q),
    .child_we    (child_we),
    .child_waddr (child_waddr),
    .child_wdata (child_wdata),
    .cnt_rd_en   (cnt_rd_en),
    .cnt_raddr   (cnt_raddr),
    .cnt_q       (cnt_q),
    .cnt_we      (cnt_we),
    .cnt_waddr   (cnt_waddr),
    .cnt_wdata   (cnt_wdata)
  );

  tpc_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_child_ram (
    .clk     (clk),
    .rd_en   (child_rd_en),
    .raddr   (child_raddr),
    .rd_data (child_q),
    .we      (child_we),
    .waddr   (child_waddr),
    .wdata   (child_wdata)
  );

  tpc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NODE_COUNT)
  ) u_count_ram (
    .clk     (clk),
    .rd_en   (cnt_rd_en),
    .raddr   (cnt_raddr),
    .rd_data (cnt_q),
    .we      (cnt_we),
    .waddr   (cnt_waddr),
    .wdata   (cnt_wdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_prefix_count_r <= res.prefix_count;
      out_status_r       <= res.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prefix_count = out_prefix_count_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

// ----- rtl/tpc_checker.sv -----
// Port-level checks for the trie prefix counter and the bind that attaches them.
// Sees only the ports of trie_prefix_counter_core; no package dependency.
`default_nettype none

module tpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_prefix_count,
  input wire logic        out_status
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prefix_count) && $stable(out_status))
    else $error("stalled result item changed");

  // A cut-short insert never reports a prefix count.
  a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_prefix_count == 16'd0)
    else $error("full status with nonzero count");

  // The table clear keeps the input stalled right after reset.
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // An accepted letter always stalls the input while the walker handles it.
  a_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted in back-to-back cycles");

  // A new result is loaded only while the walker is busy with an item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item appeared while idle");

endmodule

bind trie_prefix_counter_core tpc_checker u_tpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_prefix_count (out_prefix_count),
  .out_status       (out_status)
);

`default_nettype wire

// ----- test/tpc_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for trie_prefix_counter_core: keeps its own copy of the node table,
// built from the accepted letters, and compares every result item it sees.
// Depends on tpc_pkg.

module tpc_scoreboard #(
  parameter int NODE_COUNT = 1024,
  parameter int ALPHABET   = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [4:0]  in_letter,
  input  logic        in_word_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_prefix_count,
  input  logic        out_status,
  output int          fail_count,
  output int          words_open
);

  logic [9:0]     child_of [NODE_COUNT*ALPHABET];
  logic [15:0]    visits [NODE_COUNT];
  logic [9:0]     cur_node;
  logic [10:0]    next_free;
  bit             path_broken;
  bit             pool_full;
  tpc_pkg::res_t  expected_counts[$];
  tpc_pkg::res_t  want;

  task automatic count_visit(input logic [9:0] node);
    if (visits[node] != tpc_pkg::PREFIX_MAX) visits[node] = visits[node] + 16'd1;
  endtask

  // Follows one accepted letter through the trie and queues the result item
  // that a word end produces.
  task automatic walk_letter(input logic cmd, input logic [4:0] letter, input logic last);
    logic [9:0]    child;
    int            slot;
    tpc_pkg::res_t r;
    if (cmd == tpc_pkg::CMD_QUERY) begin
      if (!path_broken) begin
        if (letter >= ALPHABET) begin
          path_broken = 1'b1;
        end else begin
          child = child_of[cur_node*ALPHABET + letter];
          if (child == '0) path_broken = 1'b1;
          else cur_node = child;
        end
      end
    end else if (!pool_full && !path_broken && letter < ALPHABET) begin
      // The root is counted on the first letter even if the pool is already empty.
      if (cur_node == '0) count_visit('0);
      slot  = cur_node*ALPHABET + letter;
      child = child_of[slot];
      if (child == '0 && next_free >= NODE_COUNT) begin
        pool_full = 1'b1;
      end else begin
        if (child == '0) begin
          child          = next_free[9:0];
          next_free      = next_free + 11'd1;
          child_of[slot] = child;
        end
        cur_node = child;
        count_visit(child);
      end
    end
    if (last) begin
      r.prefix_count = '0;
      r.status       = tpc_pkg::STATUS_OK;
      if (cmd == tpc_pkg::CMD_QUERY) begin
        if (!path_broken) r.prefix_count = visits[cur_node];
      end else if (pool_full) begin
        r.status = tpc_pkg::STATUS_FULL;
      end
      expected_counts.push_back(r);
      cur_node    = '0;
      path_broken = 1'b0;
      pool_full   = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (child_of[i]) child_of[i] = '0;
      foreach (visits[i]) visits[i] = '0;
      cur_node    = '0;
      next_free   = 11'd1;
      path_broken = 1'b0;
      pool_full   = 1'b0;
      expected_counts.delete();
      fail_count  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: result item with none expected: prefix_count %0d status %0d",
                   $time, out_prefix_count, out_status);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (out_prefix_count !== want.prefix_count) begin
            $display("%0t: prefix_count mismatch: expected %0d, actual %0d",
                     $time, want.prefix_count, out_prefix_count);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) walk_letter(in_cmd, in_letter, in_word_end);
    end
    words_open = expected_counts.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Top of the trie_prefix_counter_core test: clock, reset, word stimulus and the
// result stall pattern. Depends on tpc_pkg, tpc_scoreboard and the RTL.

module tb;

  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam byte LETTER_BASE = 8'd97;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [4:0]  in_letter;
  logic        in_word_end;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_prefix_count;
  logic        out_status;
  int          fail_count;
  int          words_open;
  int          cycles;
  string       word_book[$];

  trie_prefix_counter_core i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_letter, .in_word_end,
    .out_valid, .out_stall, .out_prefix_count, .out_status
  );

  tpc_scoreboard i_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_letter, .in_word_end,
    .out_valid, .out_stall, .out_prefix_count, .out_status, .fail_count, .words_open
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("trie_prefix_counter_core test failed");
      $finish;
    end
  end

  task automatic send_letter(input logic cmd, input logic [4:0] letter, input logic last);
    int gap;
    gap = $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_letter   <= letter;
    in_word_end <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_text(input logic cmd, input string s);
    for (int i = 0; i < s.len(); i++)
      send_letter(cmd, 5'(s.getc(i) - LETTER_BASE), i == s.len() - 1);
  endtask

  function automatic string random_text(input int len);
    string s;
    s = "aaaaaaaa";
    for (int i = 0; i < len; i++) s.putc(i, byte'(LETTER_BASE + $urandom_range(0, 25)));
    return s.substr(0, len - 1);
  endfunction

  // Mostly inserts and queries of words seen before, so that paths are shared
  // and counts climb; others are fresh words, and some mix commands within a
  // word or use letters past 'z'.
  task automatic random_words(input int n_items);
    int    sent;
    int    pick;
    string w;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if (word_book.size() > 0 && pick < 20) begin
          w = word_book[$urandom_range(0, word_book.size() - 1)];
          if (w.len() < 8 && $urandom_range(0, 2) == 0)
            w = {w, random_text($urandom_range(1, 8 - w.len()))};
        end else begin
          w = random_text($urandom_range(1, 6));
        end
        send_text(tpc_pkg::CMD_INSERT, w);
        if (word_book.size() < 300) word_book.push_back(w);
        else word_book[$urandom_range(0, 299)] = w;
      end else if (pick < 80) begin
        if (word_book.size() > 0 && pick < 72) begin
          w = word_book[$urandom_range(0, word_book.size() - 1)];
          w = w.substr(0, $urandom_range(0, w.len() - 1));
          if ($urandom_range(0, 4) == 0)
            w.putc(w.len() - 1, byte'(LETTER_BASE + $urandom_range(0, 25)));
        end else begin
          w = random_text($urandom_range(1, 4));
        end
        send_text(tpc_pkg::CMD_QUERY, w);
      end else begin
        w = random_text($urandom_range(1, 6));
        for (int i = 0; i < w.len(); i++)
          send_letter(1'($urandom_range(0, 1)),
                      (pick >= 90 && $urandom_range(0, 2) == 0) ?
                        5'($urandom_range(26, 31)) : 5'(w.getc(i) - LETTER_BASE),
                      i == w.len() - 1);
      end
      sent += w.len();
    end
  endtask

  // Result side: a fresh stall length for every result item.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = $urandom_range(0, 9);
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    in_valid    = 1'b0;
    in_cmd      = tpc_pkg::CMD_INSERT;
    in_letter   = '0;
    in_word_end = 1'b0;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    send_text(tpc_pkg::CMD_QUERY, "a");
    send_text(tpc_pkg::CMD_INSERT, "a");
    send_text(tpc_pkg::CMD_INSERT, "ab");
    send_text(tpc_pkg::CMD_INSERT, "z");
    send_text(tpc_pkg::CMD_INSERT, "q");
    send_text(tpc_pkg::CMD_QUERY, "a");
    send_text(tpc_pkg::CMD_QUERY, "ab");
    send_text(tpc_pkg::CMD_QUERY, "abz");
    // An insert letter past 'z' is skipped; a query letter past 'z' breaks the path.
    send_letter(tpc_pkg::CMD_INSERT, 5'd31, 1'b0);
    send_letter(tpc_pkg::CMD_INSERT, 5'd0, 1'b1);
    send_letter(tpc_pkg::CMD_QUERY, 5'd0, 1'b0);
    send_letter(tpc_pkg::CMD_QUERY, 5'd30, 1'b1);
    // Commands mixed within one word; the last letter decides the kind of result.
    send_letter(tpc_pkg::CMD_INSERT, 5'd25, 1'b0);
    send_letter(tpc_pkg::CMD_QUERY, 5'd25, 1'b1);
    send_letter(tpc_pkg::CMD_QUERY, 5'd0, 1'b0);
    send_letter(tpc_pkg::CMD_INSERT, 5'd1, 1'b1);
    send_text(tpc_pkg::CMD_QUERY, "ab");
    send_letter(tpc_pkg::CMD_INSERT, 5'd26, 1'b1);

    random_words(150);
    // Long fresh words use up the node pool; later inserts run into a full pool.
    repeat (150) send_text(tpc_pkg::CMD_INSERT, random_text(8));
    random_words(150);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (words_open == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("trie_prefix_counter_core test passed");
    end else begin
      $display("trie_prefix_counter_core test failed");
    end
    $finish;
  end

endmodule
